@@ design/tls_hello_extension_parser_macros.svh @@
// assertion helpers for the extension parser
`ifndef TLS_HELLO_EXTENSION_PARSER_MACROS_SVH
`define TLS_HELLO_EXTENSION_PARSER_MACROS_SVH

`define THEP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define THEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/thep_pkg.sv @@
package thep_pkg;

  typedef struct packed {
    logic        command;
    logic [15:0] ext_type;
    logic [15:0] body_length;
    logic [23:0] body_offset;
    logic [7:0]  data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        group_offered;
    logic        sigalg_ecdsa;
    logic        sigalg_rsa_pss;
    logic        psk_plain_mode;
    logic        psk_dhe_mode;
    logic        share_found;
    logic [15:0] plaintext_limit;
    logic [23:0] binder_start;
    logic [15:0] span_start;
    logic [15:0] span_length;
  } out_beat_t;

  typedef enum logic [3:0] {
    K_SNI = 4'd0, K_GROUPS = 4'd1, K_SIGALGS = 4'd2, K_ALPN = 4'd3,
    K_RSL = 4'd4, K_PSK = 4'd5, K_VERSIONS = 4'd6, K_COOKIE = 4'd7,
    K_MODES = 4'd8, K_KEYSHARE = 4'd9, K_PADDING = 4'd10, K_EARLY = 4'd11,
    K_QUIC = 4'd12, K_UNKNOWN = 4'd13
  } kind_t;

  typedef enum logic [16:0] {
    P_IDLE     = 17'h00001, P_DONE    = 17'h00002, P_SKIP    = 17'h00004,
    P_LIST_HI  = 17'h00008, P_LIST_LO = 17'h00010, P_LIST8   = 17'h00020,
    P_CP_HI    = 17'h00040, P_CP_LO   = 17'h00080, P_MODE    = 17'h00100,
    P_SNI_TYPE = 17'h00200, P_LEN_HI  = 17'h00400, P_LEN_LO  = 17'h00800,
    P_LEN8     = 17'h01000, P_BYTES   = 17'h02000, P_BIND_HI = 17'h04000,
    P_BIND_LO  = 17'h08000, P_BBYTES  = 17'h10000
  } phase_t;

  localparam logic [2:0] A_OK = 3'd0;
  localparam logic [2:0] A_DECODE = 3'd1;
  localparam logic [2:0] A_ILLEGAL = 3'd2;
  localparam logic [2:0] A_VERSION = 3'd3;
  localparam logic [2:0] A_UNSUPPORTED = 3'd4;

  localparam int F_GROUP = 0;
  localparam int F_ECDSA = 1;
  localparam int F_PSS = 2;
  localparam int F_PLAIN = 3;
  localparam int F_DHE = 4;
  localparam int F_SHARE = 5;

  localparam logic [1:0] CFG_KEX_GROUP = 2'd0;
  localparam logic [1:0] CFG_SHARE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_QUIC = 2'd2;

  localparam logic [16:0] RSL_MIN = 17'd64;
  localparam logic [16:0] IDENT_LIST_MIN = 17'd7;
  localparam logic [16:0] BINDERS_MIN = 17'd33;
  localparam logic [7:0]  BINDER_MIN = 8'd32;
  localparam logic [17:0] AGE_LEN = 18'd4;
  localparam logic [15:0] SIG_ECDSA = 16'h0403;
  localparam logic [15:0] SIG_PSS = 16'h0804;
  localparam logic [15:0] TLS13 = 16'h0304;

  function automatic kind_t kind_of(input logic [15:0] t);
    kind_t k;
    case (t)
      16'd0:  k = K_SNI;
      16'd10: k = K_GROUPS;
      16'd13: k = K_SIGALGS;
      16'd16: k = K_ALPN;
      16'd21: k = K_PADDING;
      16'd28: k = K_RSL;
      16'd41: k = K_PSK;
      16'd42: k = K_EARLY;
      16'd43: k = K_VERSIONS;
      16'd44: k = K_COOKIE;
      16'd45: k = K_MODES;
      16'd51: k = K_KEYSHARE;
      16'd57: k = K_QUIC;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

@@ design/thep_core.sv @@
module thep_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat_go,
  input  thep_pkg::in_beat_t beat,
  input  logic [15:0]        kex_group,
  input  logic [15:0]        share_length,
  input  logic               quic_transport,
  output logic               res_go,
  output thep_pkg::out_beat_t res
);
  import thep_pkg::*;

  kind_t       kind_r, kind_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] body_left_r, body_left_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [16:0] list_left_r, list_left_nxt;
  logic [15:0] entry_left_r, entry_left_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [2:0]  alert_r, alert_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic [23:0] offset_r, offset_nxt;
  logic [31:0] span_r, span_nxt;
  logic [15:0] limit_r, limit_nxt;

  logic [15:0] v;
  logic [7:0]  b;
  logic [16:0] v17, b17, rem17;
  logic [15:0] rem;
  logic        finish;
  logic        match;
  logic [16:0] list_dec;
  logic [2:0]  fin_alert;

  always_comb begin
    kind_nxt = kind_r;
    phase_nxt = phase_r;
    body_left_nxt = body_left_r;
    pos_nxt = pos_r;
    list_left_nxt = list_left_r;
    entry_left_nxt = entry_left_r;
    shift_nxt = shift_r;
    alert_nxt = alert_r;
    flags_nxt = flags_r;
    offset_nxt = offset_r;
    span_nxt = span_r;
    limit_nxt = limit_r;
    finish = 1'b0;
    b = beat.data_byte;
    v = {shift_r, b};
    v17 = {1'b0, v};
    b17 = {9'd0, b};
    rem = body_left_r - 16'd1;
    rem17 = {1'b0, rem};
    match = entry_left_r != 16'd0;
    list_dec = (list_left_r >= 17'd2) ? list_left_r - 17'd2 : 17'd0;
    if (beat_go && !beat.command) begin
      kind_nxt = kind_of(beat.ext_type);
      body_left_nxt = beat.body_length;
      pos_nxt = '0;
      list_left_nxt = '0;
      entry_left_nxt = '0;
      shift_nxt = '0;
      alert_nxt = A_OK;
      flags_nxt = '0;
      span_nxt = '0;
      limit_nxt = '0;
      offset_nxt = (kind_nxt == K_PSK) ? beat.body_offset : 24'd0;
      unique case (kind_nxt)
        K_VERSIONS, K_MODES: phase_nxt = P_LIST8;
        K_PADDING: phase_nxt = P_SKIP;
        K_EARLY: phase_nxt = P_DONE;
        K_QUIC: begin
          phase_nxt = P_SKIP;
          if (quic_transport) span_nxt = {16'd0, beat.body_length};
          else alert_nxt = A_UNSUPPORTED;
        end
        K_UNKNOWN: begin
          phase_nxt = P_SKIP;
          alert_nxt = A_DECODE;
        end
        default: phase_nxt = P_LIST_HI;
      endcase
      finish = beat.body_length == 16'd0;
    end else if (beat_go && phase_r != P_IDLE && body_left_r != 16'd0) begin
      body_left_nxt = rem;
      pos_nxt = pos_r + 16'd1;
      finish = rem == 16'd0;
      unique case (phase_r)
        P_DONE: begin
          if (alert_r == A_OK) alert_nxt = A_DECODE;
          phase_nxt = P_SKIP;
        end
        P_LIST_HI: begin shift_nxt = b; phase_nxt = P_LIST_LO; end
        P_CP_HI: begin shift_nxt = b; phase_nxt = P_CP_LO; end
        P_LEN_HI: begin shift_nxt = b; phase_nxt = P_LEN_LO; end
        P_BIND_HI: begin shift_nxt = b; phase_nxt = P_BIND_LO; end
        P_LIST_LO: begin
          case (kind_r)
            K_SNI: begin list_left_nxt = v17; phase_nxt = P_SNI_TYPE; end
            K_GROUPS, K_SIGALGS: begin
              if (v < 16'd2 || v[0] || v > rem) alert_nxt = A_DECODE;
              else begin list_left_nxt = v17; phase_nxt = P_CP_HI; end
            end
            K_ALPN: begin
              if (v < 16'd2 || v > rem) alert_nxt = A_DECODE;
              else begin list_left_nxt = v17; phase_nxt = P_LEN8; end
            end
            K_RSL: begin
              if (v17 < RSL_MIN) alert_nxt = A_ILLEGAL;
              else begin limit_nxt = v - 16'd1; phase_nxt = P_DONE; end
            end
            K_PSK: begin
              if (v17 < IDENT_LIST_MIN || v > rem) alert_nxt = A_DECODE;
              else begin
                list_left_nxt = v17;
                offset_nxt = offset_r + 24'd2 + {8'd0, v};
                phase_nxt = P_LEN_HI;
              end
            end
            K_COOKIE: begin
              if (v == 16'd0 || v > rem) alert_nxt = A_DECODE;
              else begin
                span_nxt = {pos_r + 16'd1, v};
                entry_left_nxt = v;
                phase_nxt = P_BYTES;
              end
            end
            default: begin
              if (v > rem) alert_nxt = A_DECODE;
              else begin
                list_left_nxt = v17;
                phase_nxt = (v == 16'd0) ? P_DONE : P_CP_HI;
              end
            end
          endcase
        end
        P_LIST8: begin
          if (kind_r == K_VERSIONS) begin
            if (b < 8'd2 || b[0] || b17 > rem17) alert_nxt = A_DECODE;
            else begin
              list_left_nxt = b17; entry_left_nxt = '0; phase_nxt = P_CP_HI;
            end
          end else begin
            if (b == 8'd0 || b17 > rem17) alert_nxt = A_DECODE;
            else begin list_left_nxt = b17; phase_nxt = P_MODE; end
          end
        end
        P_MODE: begin
          if (b == 8'd0) flags_nxt[F_PLAIN] = 1'b1;
          if (b == 8'd1) flags_nxt[F_DHE] = 1'b1;
          list_left_nxt = list_left_r - 17'd1;
          if (list_left_nxt == 17'd0) phase_nxt = P_DONE;
        end
        P_CP_LO: begin
          if (kind_r == K_KEYSHARE) begin
            entry_left_nxt = {15'd0, v == kex_group};
            phase_nxt = P_LEN_HI;
          end else begin
            if (kind_r == K_GROUPS && v == kex_group) flags_nxt[F_GROUP] = 1'b1;
            if (kind_r == K_SIGALGS && v == SIG_ECDSA) flags_nxt[F_ECDSA] = 1'b1;
            if (kind_r == K_SIGALGS && v == SIG_PSS) flags_nxt[F_PSS] = 1'b1;
            if (kind_r == K_VERSIONS && v == TLS13) entry_left_nxt = 16'd1;
            list_left_nxt = list_dec;
            if (list_dec != 17'd0) phase_nxt = P_CP_HI;
            else if (kind_r == K_VERSIONS && entry_left_nxt == 16'd0)
              alert_nxt = A_VERSION;
            else phase_nxt = P_DONE;
          end
        end
        P_SNI_TYPE: begin
          if (b != 8'd0) alert_nxt = A_DECODE;
          else phase_nxt = P_LEN_HI;
        end
        P_LEN_LO: begin
          if (kind_r == K_SNI) begin
            if (v == 16'd0 || v > rem || {1'b0, list_left_r} != 18'd3 + {2'd0, v})
              alert_nxt = A_DECODE;
            else begin
              span_nxt = {pos_r + 16'd1, v};
              entry_left_nxt = v;
              phase_nxt = P_BYTES;
            end
          end else if (kind_r == K_KEYSHARE) begin
            if (v == 16'd0 || v > rem) alert_nxt = A_DECODE;
            else if (match && v != share_length) alert_nxt = A_ILLEGAL;
            else if (18'd4 + {2'd0, v} > {1'b0, list_left_r}) alert_nxt = A_DECODE;
            else begin
              if (match && !flags_r[F_SHARE]) begin
                flags_nxt[F_SHARE] = 1'b1;
                span_nxt = {pos_r + 16'd1, v};
              end
              list_left_nxt = list_left_r - 17'd4 - v17;
              entry_left_nxt = v;
              phase_nxt = P_BYTES;
            end
          end else begin
            if (v == 16'd0 || {2'd0, v} + AGE_LEN > {2'd0, rem} ||
                {2'd0, v} + 18'd2 + AGE_LEN > {1'b0, list_left_r})
              alert_nxt = A_DECODE;
            else begin
              list_left_nxt = list_left_r - v17 - 17'd6;
              entry_left_nxt = v + 16'd4;
              phase_nxt = P_BYTES;
            end
          end
        end
        P_LEN8: begin
          if (kind_r == K_PSK) begin
            if (b < BINDER_MIN || b17 > rem17 || b17 + 17'd1 > list_left_r)
              alert_nxt = A_DECODE;
            else begin
              list_left_nxt = list_left_r - 17'd1 - b17;
              entry_left_nxt = {8'd0, b};
              phase_nxt = P_BBYTES;
            end
          end else begin
            if (b == 8'd0 || b17 > rem17 || b17 + 17'd1 > list_left_r)
              alert_nxt = A_DECODE;
            else begin
              list_left_nxt = list_left_r - 17'd1 - b17;
              entry_left_nxt = {8'd0, b};
              phase_nxt = P_BYTES;
            end
          end
        end
        P_BYTES: begin
          if (entry_left_r != 16'd0) entry_left_nxt = entry_left_r - 16'd1;
          if (entry_left_nxt == 16'd0) begin
            case (kind_r)
              K_ALPN: phase_nxt = (list_left_r != 17'd0) ? P_LEN8 : P_DONE;
              K_KEYSHARE: phase_nxt = (list_left_r != 17'd0) ? P_CP_HI : P_DONE;
              K_PSK: phase_nxt = (list_left_r != 17'd0) ? P_LEN_HI : P_BIND_HI;
              default: phase_nxt = P_DONE;
            endcase
          end
        end
        P_BIND_LO: begin
          if (v17 < BINDERS_MIN || v > rem) alert_nxt = A_DECODE;
          else begin list_left_nxt = v17; phase_nxt = P_LEN8; end
        end
        P_BBYTES: begin
          if (entry_left_r != 16'd0) entry_left_nxt = entry_left_r - 16'd1;
          if (entry_left_nxt == 16'd0)
            phase_nxt = (list_left_r != 17'd0) ? P_LEN8 : P_DONE;
        end
        default: ;
      endcase
      // an error in this beat wins only if none came before
      if (alert_nxt != alert_r) begin
        phase_nxt = P_SKIP;
        if (alert_r != A_OK) alert_nxt = alert_r;
      end
    end
    fin_alert = alert_nxt;
    if (alert_nxt == A_OK && phase_nxt != P_DONE && phase_nxt != P_SKIP)
      fin_alert = A_DECODE;
    res = '0;
    res.status = fin_alert;
    if (fin_alert == A_OK) begin
      res.group_offered = flags_nxt[F_GROUP];
      res.sigalg_ecdsa = flags_nxt[F_ECDSA];
      res.sigalg_rsa_pss = flags_nxt[F_PSS];
      res.psk_plain_mode = flags_nxt[F_PLAIN];
      res.psk_dhe_mode = flags_nxt[F_DHE];
      res.share_found = flags_nxt[F_SHARE];
      res.plaintext_limit = limit_nxt;
      res.binder_start = offset_nxt;
      res.span_start = span_nxt[31:16];
      res.span_length = span_nxt[15:0];
    end
    if (finish) phase_nxt = P_IDLE;
    res_go = finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= K_SNI;
      phase_r <= P_IDLE;
      body_left_r <= '0;
      pos_r <= '0;
      list_left_r <= '0;
      entry_left_r <= '0;
      shift_r <= '0;
      alert_r <= A_OK;
      flags_r <= '0;
      offset_r <= '0;
      span_r <= '0;
      limit_r <= '0;
    end else begin
      kind_r <= kind_nxt;
      phase_r <= phase_nxt;
      body_left_r <= body_left_nxt;
      pos_r <= pos_nxt;
      list_left_r <= list_left_nxt;
      entry_left_r <= entry_left_nxt;
      shift_r <= shift_nxt;
      alert_r <= alert_nxt;
      flags_r <= flags_nxt;
      offset_r <= offset_nxt;
      span_r <= span_nxt;
      limit_r <= limit_nxt;
    end
  end

endmodule

@@ design/tls_hello_extension_parser.sv @@
// channel  | direction | handshake         | payload
// in_      | input     | in_valid/in_stall | thep_pkg::in_beat_t
// out_     | output    | out_valid/out_stall | thep_pkg::out_beat_t
// cfg_     | input     | cfg_we            | index 2 bits, data 16 bits
// one beat per cycle while in_stall is low; the parser state updates on the beat after the input register
// a result passes through the input register and then the output buffer after the last body beat is accepted
// a two-entry output buffer absorbs out_stall; in_stall rises when it would be full
// rst_n is synchronous; registers return to reset values, no clearing pass
module tls_hello_extension_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  thep_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output thep_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import thep_pkg::*;
  `include "tls_hello_extension_parser_macros.svh"

  logic [15:0] kex_group_r;
  logic [15:0] share_length_r;
  logic        quic_r;
  logic        in_go;
  in_beat_t    beat_r;
  logic        beat_v_r;
  logic        res_go;
  out_beat_t   res;
  out_beat_t   q0_r, q1_r;
  logic [1:0]  cnt_r;
  logic        pop;
  logic [1:0]  pend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kex_group_r <= 16'd29;
      share_length_r <= 16'd32;
      quic_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEX_GROUP: kex_group_r <= cfg_data;
        CFG_SHARE_LENGTH: share_length_r <= cfg_data;
        CFG_QUIC: quic_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stall when the buffer would be full after this edge
  assign pend = cnt_r + {1'b0, res_go} - {1'b0, pop};
  assign in_stall = pend >= 2'd2;
  assign in_go = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) beat_v_r <= 1'b0;
    else beat_v_r <= in_go;
    if (in_go) beat_r <= in_data;
  end

  thep_core u_core (
    .clk(clk), .rst_n(rst_n), .beat_go(beat_v_r), .beat(beat_r),
    .kex_group(kex_group_r), .share_length(share_length_r),
    .quic_transport(quic_r), .res_go(res_go), .res(res)
  );

  assign out_valid = cnt_r != 2'd0;
  assign out_data = q0_r;
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_r + {1'b0, res_go} - {1'b0, pop};
    if (pop) begin
      if (res_go && cnt_r == 2'd1) q0_r <= res;
      else q0_r <= q1_r;
      if (res_go && cnt_r == 2'd2) q1_r <= res;
    end else if (res_go) begin
      if (cnt_r == 2'd0) q0_r <= res;
      else q1_r <= res;
    end
  end

  `THEP_ASSERT_IMPL(a_no_overflow, clk, rst_n, res_go && !pop, cnt_r != 2'd2)
  `THEP_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3)
  `THEP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)

endmodule
